// ===== hw/rtl/idpa_pkg.sv =====
// ----------------------------------------------------------------------------
// idpa_pkg
// Shared types, widths and codes of the ID pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package idpa_pkg;

    localparam int unsigned ID_W       = 32;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned EC_W       = 11;
    localparam int unsigned IDX_MAX_W  = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned EFF_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 8'd1;

    localparam logic [EC_W-1:0] EC_RESET = 11'd1024;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_SET   = 2'd2;
    localparam logic [1:0] MODE_GET   = 2'd3;

    typedef enum logic [2:0] {
        K_ALLOC  = 3'd0,
        K_FREE   = 3'd1,
        K_SET    = 3'd2,
        K_GET    = 3'd3,
        K_REJECT = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [IDX_MAX_W-1:0] idx;
        logic [ID_W-1:0]      tag;
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0] base;
        logic [EC_W-1:0] entry_count;
        logic            rebuild;
    } t_cfg;

    typedef struct packed {
        logic [ID_W-1:0]    granted_id;
        logic [ID_W-1:0]    tag_value;
        logic               accepted;
        logic [COUNT_W-1:0] used_count;
    } t_result;

    // Entry count clamped to the range 2 .. max_entries.
    function automatic logic [EFF_W-1:0] eff_count(input logic [EC_W-1:0] ec,
                                                   input int unsigned max_entries);
        logic [31:0] ec32;
        logic [31:0] res;
        ec32 = 32'(ec);
        if (ec32 < 32'd2) begin
            res = 32'd2;
        end else if (ec32 > max_entries) begin
            res = max_entries;
        end else begin
            res = ec32;
        end
        return res[EFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/idpa_ram.sv =====
// ----------------------------------------------------------------------------
// idpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module idpa_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/idpa_front.sv =====
// ----------------------------------------------------------------------------
// idpa_front
// Holds the configuration registers, classifies each request against the ID
// range and queues the classified operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module idpa_front #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [idpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [idpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_req_valid,
    output logic                                  o_req_ready,
    input  wire logic [1:0]                       i_req_mode,
    input  wire logic [idpa_pkg::ID_W-1:0]        i_req_id,
    input  wire logic [idpa_pkg::ID_W-1:0]        i_req_tag,
    input  wire logic                             i_clearing,
    output idpa_pkg::t_cfg                        o_cfg,
    output logic                                  o_q_valid,
    output idpa_pkg::t_op                         o_q_op,
    input  wire logic                             i_q_pop
);

    logic [idpa_pkg::ID_W-1:0]  r_base;
    logic [idpa_pkg::EC_W-1:0]  r_ec;
    idpa_pkg::t_op              r_q [2];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;

    logic                       cfg_fire;
    logic                       push;
    logic [idpa_pkg::EFF_W-1:0] n_ent;
    logic [idpa_pkg::ID_W-1:0]  off;
    logic                       id_valid;
    idpa_pkg::t_op              op;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_ec   <= idpa_pkg::EC_RESET;
        end else if (cfg_fire) begin
            if (i_cfg_index == idpa_pkg::CFG_BASE_INDEX) begin
                r_base <= i_cfg_data;
            end else if (i_cfg_index == idpa_pkg::CFG_ENTRY_COUNT) begin
                r_ec <= i_cfg_data[idpa_pkg::EC_W-1:0];
            end
        end
    end

    always_comb begin
        o_cfg.base        = r_base;
        o_cfg.entry_count = r_ec;
        o_cfg.rebuild     = cfg_fire && ((i_cfg_index == idpa_pkg::CFG_BASE_INDEX) ||
                                         (i_cfg_index == idpa_pkg::CFG_ENTRY_COUNT));
    end

    assign n_ent    = idpa_pkg::eff_count(r_ec, MAX_ENTRIES);
    assign off      = i_req_id - r_base;
    assign id_valid = (i_req_id != '0) && (off < 32'(n_ent));

    always_comb begin
        op.idx = off[idpa_pkg::IDX_MAX_W-1:0];
        op.tag = i_req_tag;
        unique case (i_req_mode)
            idpa_pkg::MODE_ALLOC: op.kind = idpa_pkg::K_ALLOC;
            idpa_pkg::MODE_FREE:  op.kind = (id_valid && off != '0) ? idpa_pkg::K_FREE
                                                                    : idpa_pkg::K_REJECT;
            idpa_pkg::MODE_SET:   op.kind = id_valid ? idpa_pkg::K_SET : idpa_pkg::K_REJECT;
            idpa_pkg::MODE_GET:   op.kind = id_valid ? idpa_pkg::K_GET : idpa_pkg::K_REJECT;
            default:              op.kind = idpa_pkg::K_REJECT;
        endcase
    end

    assign o_req_ready = (r_cnt != 2'd2) && !i_clearing;
    assign push        = i_req_valid && o_req_ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_op      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/idpa_back.sv =====
// ----------------------------------------------------------------------------
// idpa_back
// Sequencer that carries out queued operations on the free list and the tag
// store, rebuilds the list after reset and configuration writes, and holds
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module idpa_back #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned TAG_BITS    = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire idpa_pkg::t_cfg    i_cfg,
    input  wire logic              i_q_valid,
    input  wire idpa_pkg::t_op     i_q_op,
    output logic                   o_q_pop,
    output logic                   o_clearing,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output idpa_pkg::t_result      o_res
);

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_ALLOC    = 8'b0000_0100,
        ST_RESP     = 8'b0000_1000,
        ST_GET      = 8'b0001_0000,
        ST_FREE_UNL = 8'b0010_0000,
        ST_FREE_APP = 8'b0100_0000,
        ST_FREE_END = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    logic [IDX_W-1:0]             r_head, n_head;
    logic [IDX_W-1:0]             r_tail, n_tail;
    logic                         r_empty, n_empty;
    logic [idpa_pkg::COUNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0]             r_clr_idx, n_clr_idx;
    idpa_pkg::t_op                r_op, n_op;
    logic                         r_res_valid, n_res_valid;
    idpa_pkg::t_result            r_res, n_res;

    logic                         nx_we, pv_we, fl_we, tg_we, rd_en;
    logic [IDX_W-1:0]             nx_waddr, pv_waddr, fl_waddr, tg_waddr;
    logic [IDX_W-1:0]             nx_wdata, pv_wdata;
    logic                         fl_wdata;
    logic [TAG_BITS-1:0]          tg_wdata;
    logic [IDX_W-1:0]             nx_raddr, q_idx;
    logic [IDX_W-1:0]             nx_rdata, pv_rdata;
    logic                         fl_rdata;
    logic [TAG_BITS-1:0]          tg_rdata;

    logic [CNT_W-1:0]             n_ent;
    logic [CNT_W-1:0]             ci_ext, ci_plus;
    logic                         ci_in_list;
    logic [IDX_W-1:0]             e;
    logic                         fire;
    logic [63:0]                  tag_in64, tag_out64;

    assign n_ent      = CNT_W'(idpa_pkg::eff_count(i_cfg.entry_count, MAX_ENTRIES));
    assign ci_ext     = CNT_W'(r_clr_idx);
    assign ci_plus    = ci_ext + CNT_W'(1);
    assign ci_in_list = (r_clr_idx != '0) && (ci_ext < n_ent);
    assign e          = r_op.idx[IDX_W-1:0];
    assign q_idx      = i_q_op.idx[IDX_W-1:0];
    assign fire       = !r_res_valid || i_res_ready;
    assign tag_in64   = 64'(r_op.tag);
    assign tag_out64  = 64'(tg_rdata);

    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign rd_en    = o_q_pop;
    assign nx_raddr = (i_q_op.kind == idpa_pkg::K_ALLOC) ? r_head : q_idx;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_count     = r_count;
        n_clr_idx   = r_clr_idx;
        n_op        = r_op;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;

        nx_we    = 1'b0;
        nx_waddr = e;
        nx_wdata = '0;
        pv_we    = 1'b0;
        pv_waddr = e;
        pv_wdata = '0;
        fl_we    = 1'b0;
        fl_waddr = e;
        fl_wdata = 1'b0;
        tg_we    = 1'b0;
        tg_waddr = e;
        tg_wdata = '0;

        unique case (r_state)
            ST_CLEAR: begin
                nx_we    = 1'b1;
                nx_waddr = r_clr_idx;
                nx_wdata = ((r_clr_idx != '0) && (ci_plus < n_ent)) ? IDX_W'(ci_plus) : '0;
                pv_we    = 1'b1;
                pv_waddr = r_clr_idx;
                pv_wdata = ci_in_list ? (r_clr_idx - IDX_W'(1)) : '0;
                fl_we    = 1'b1;
                fl_waddr = r_clr_idx;
                fl_wdata = ci_in_list;
                tg_we    = 1'b1;
                tg_waddr = r_clr_idx;
                tg_wdata = '0;
                if (r_clr_idx == IDX_W'(MAX_ENTRIES - 1)) begin
                    n_head  = IDX_W'(1);
                    n_tail  = IDX_W'(n_ent - CNT_W'(1));
                    n_empty = 1'b0;
                    n_count = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_op = i_q_op;
                    unique case (i_q_op.kind)
                        idpa_pkg::K_ALLOC: n_state = ST_ALLOC;
                        idpa_pkg::K_FREE:  n_state = ST_FREE_UNL;
                        idpa_pkg::K_GET:   n_state = ST_GET;
                        default:           n_state = ST_RESP;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (fire) begin
                    n_res_valid      = 1'b1;
                    n_res.tag_value  = '0;
                    n_res.granted_id = '0;
                    n_res.accepted   = 1'b0;
                    if (!r_empty) begin
                        if (r_head == r_tail) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = nx_rdata;
                        end
                        fl_we    = 1'b1;
                        fl_waddr = r_head;
                        fl_wdata = 1'b0;
                        if (r_count != '1) begin
                            n_count = r_count + idpa_pkg::COUNT_W'(1);
                        end
                        n_res.granted_id = i_cfg.base + idpa_pkg::ID_W'(r_head);
                        n_res.accepted   = 1'b1;
                    end
                    n_res.used_count = n_count;
                    n_state          = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (fire) begin
                    if (r_op.kind == idpa_pkg::K_SET) begin
                        tg_we    = 1'b1;
                        tg_wdata = tag_in64[TAG_BITS-1:0];
                    end
                    n_res_valid      = 1'b1;
                    n_res.granted_id = '0;
                    n_res.tag_value  = '0;
                    n_res.accepted   = (r_op.kind == idpa_pkg::K_SET);
                    n_res.used_count = r_count;
                    n_state          = ST_IDLE;
                end
            end
            ST_GET: begin
                if (fire) begin
                    n_res_valid      = 1'b1;
                    n_res.granted_id = '0;
                    n_res.tag_value  = tag_out64[idpa_pkg::ID_W-1:0];
                    n_res.accepted   = 1'b1;
                    n_res.used_count = r_count;
                    n_state          = ST_IDLE;
                end
            end
            ST_FREE_UNL: begin
                tg_we    = 1'b1;
                tg_wdata = '0;
                if (fl_rdata) begin
                    if (e == r_head && e == r_tail) begin
                        n_empty = 1'b1;
                    end else if (e == r_head) begin
                        n_head = nx_rdata;
                    end else if (e == r_tail) begin
                        n_tail = pv_rdata;
                    end else begin
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata;
                        nx_wdata = nx_rdata;
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = pv_rdata;
                    end
                end
                n_state = ST_FREE_APP;
            end
            ST_FREE_APP: begin
                if (r_empty) begin
                    n_head  = e;
                    n_empty = 1'b0;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = r_tail;
                    nx_wdata = e;
                    pv_we    = 1'b1;
                    pv_waddr = e;
                    pv_wdata = r_tail;
                end
                n_state = ST_FREE_END;
            end
            ST_FREE_END: begin
                if (fire) begin
                    nx_we    = 1'b1;
                    nx_wdata = '0;
                    fl_we    = 1'b1;
                    fl_wdata = 1'b1;
                    n_tail   = e;
                    if (r_count != '0) begin
                        n_count = r_count - idpa_pkg::COUNT_W'(1);
                    end
                    n_res_valid      = 1'b1;
                    n_res.granted_id = '0;
                    n_res.tag_value  = '0;
                    n_res.accepted   = 1'b1;
                    n_res.used_count = n_count;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        if (i_cfg.rebuild) begin
            n_state   = ST_CLEAR;
            n_clr_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= IDX_W'(1);
            r_tail      <= '0;
            r_empty     <= 1'b0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_res <= n_res;
    end

    idpa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (rd_en),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    idpa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (rd_en),
        .i_raddr (q_idx),
        .o_rdata (pv_rdata)
    );

    idpa_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_re    (rd_en),
        .i_raddr (q_idx),
        .o_rdata (fl_rdata)
    );

    idpa_ram #(.WIDTH(TAG_BITS), .DEPTH(MAX_ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tg_we),
        .i_waddr (tg_waddr),
        .i_wdata (tg_wdata),
        .i_re    (rd_en),
        .i_raddr (q_idx),
        .o_rdata (tg_rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/id_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// id_pool_allocator
// Free-list ID allocator with one object tag per ID.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake            | Content
//   ---------+-----------+----------------------+------------------------------
//   s_axis   | in        | tvalid / tready      | request: mode, id, tag
//   m_axis   | out       | tvalid / tready      | result: id, tag, status, count
//   cfg      | in        | valid / ready        | register index and data
//
// Allocate, set, get and rejected requests go to their response state; a free
// goes through the unlink, append and end states, set by the reads and ordered
// writes on the link RAMs. After reset and each base or entry-count write, a
// clearing pass over all MAX_ENTRIES entries rebuilds the list; no request is
// taken meanwhile. A two-entry queue lets requests be taken while a result
// waits on m_axis; a stalled result holds the sequencer in its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module id_pool_allocator #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned TAG_BITS    = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // Fields from bit 0: request_id[31:0], object_tag[63:32].
    input  wire logic [63:0]                     i_s_axis_tdata,
    // Fields from bit 0: mode[1:0].
    input  wire logic [1:0]                      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // Fields from bit 0: granted_id[31:0], tag_value[63:32], accepted[64],
    // used_count[75:65], zero fill[79:76].
    output logic [79:0]                          o_m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [idpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [idpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    idpa_pkg::t_cfg    cfg;
    idpa_pkg::t_op     q_op;
    idpa_pkg::t_result res;
    logic              q_valid;
    logic              q_pop;
    logic              clearing;

    idpa_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req_mode  (i_s_axis_tuser),
        .i_req_id    (i_s_axis_tdata[31:0]),
        .i_req_tag   (i_s_axis_tdata[63:32]),
        .i_clearing  (clearing),
        .o_cfg       (cfg),
        .o_q_valid   (q_valid),
        .o_q_op      (q_op),
        .i_q_pop     (q_pop)
    );

    idpa_back #(.MAX_ENTRIES(MAX_ENTRIES), .TAG_BITS(TAG_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {4'b0000, res.used_count, res.accepted,
                             res.tag_value, res.granted_id};

endmodule

`default_nettype wire
